[rtl/bcd_pkg.sv]
// ----------------------------------------------------------------------------
// bcd_pkg
// Shared types and constants of the backoff cheat detector.
// ----------------------------------------------------------------------------
package bcd_pkg;

  localparam int unsigned ALU_W  = 48;
  localparam int unsigned EXT_W  = ALU_W - 32;
  localparam int unsigned CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALID_GAP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHEAT_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SCORE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_SHIFT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NEW_NODE_OFFSET = 3'd4;

  // configuration reset values
  localparam logic [31:0] RST_MAX_VALID_GAP   = 32'd3276;
  localparam logic [31:0] RST_CHEAT_THRESHOLD = 32'd1500;
  localparam logic [3:0]  RST_MAX_SCORE       = 4'd10;
  localparam logic [3:0]  RST_ALPHA_SHIFT     = 4'd3;
  localparam logic [31:0] RST_NEW_NODE_OFFSET = 32'd983040;

  localparam logic [3:0]  SCORE_SAT = 4'hF;
  localparam logic [31:0] DROP_SAT  = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    V_DELIVER   = 2'd0,
    V_DROP      = 2'd1,
    V_NEWBL     = 2'd2,
    V_UNTRACKED = 2'd3
  } verdict_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic [ALU_W-1:0] value;
    logic             borrow;  // set on a subtract that went below zero
  } alu_res_t;

  // one table entry, written as a whole
  typedef struct packed {
    logic [63:0] addr;
    logic [31:0] avg;
    logic [3:0]  score;
    logic [31:0] last;
    logic        bl;
  } entry_t;

endpackage

[rtl/bcd_alu.sv]
// ----------------------------------------------------------------------------
// bcd_alu
// Shared 48-bit add/subtract unit with borrow flag.
// ----------------------------------------------------------------------------
module bcd_alu import bcd_pkg::*; (
  input  alu_op_e          op_i,
  input  logic [ALU_W-1:0] a_i,
  input  logic [ALU_W-1:0] b_i,
  output alu_res_t         res_o
);

  logic [ALU_W-1:0] b_mux;
  logic [ALU_W:0]   sum;

  always_comb begin
    b_mux = (op_i == ALU_SUB) ? ~b_i : b_i;
    sum   = {1'b0, a_i} + {1'b0, b_mux} + {{ALU_W{1'b0}}, (op_i == ALU_SUB)};
    res_o.value  = sum[ALU_W-1:0];
    res_o.borrow = (op_i == ALU_SUB) && !sum[ALU_W];
  end

endmodule

[rtl/bcd_table.sv]
// ----------------------------------------------------------------------------
// bcd_table
// Node table memory: one whole-entry write port, one registered read port.
// ----------------------------------------------------------------------------
module bcd_table import bcd_pkg::*; #(
  parameter int unsigned NODE_ENTRIES = 16
) (
  input  logic                                            clk_i,
  input  logic                                            wr_en_i,
  input  logic [((NODE_ENTRIES > 1) ? $clog2(NODE_ENTRIES) : 1)-1:0] wr_idx_i,
  input  entry_t                                          wr_entry_i,
  input  logic [((NODE_ENTRIES > 1) ? $clog2(NODE_ENTRIES) : 1)-1:0] rd_idx_i,
  output entry_t                                          rd_entry_o
);

  entry_t mem [NODE_ENTRIES];
  entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_idx_i];
  end

  assign rd_entry_o = rd_q;

endmodule

[rtl/backoff_cheat_detector.sv]
// ----------------------------------------------------------------------------
// backoff_cheat_detector
// Tracks sender inter-arrival EWMA and blacklists nodes cheating on backoff.
// ----------------------------------------------------------------------------
// One transaction at a time, set by the one-entry-per-cycle scan and the
// shared adder; busy holds through done_o.
// Receiver cannot stall. Reset: async, active low; table itself not cleared.
// ----------------------------------------------------------------------------
module backoff_cheat_detector import bcd_pkg::*; #(
  parameter int unsigned NODE_ENTRIES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i,
  // command
  input  logic                 start,
  output logic                 busy,
  input  logic [63:0]          sender_address_i,
  input  logic [31:0]          arrival_time_i,
  // result
  output logic                 done_o,
  output logic [1:0]           verdict_o,
  output logic [3:0]           entry_index_o,
  output logic [31:0]          average_gap_o,
  output logic [3:0]           score_o,
  output logic [31:0]          dropped_total_o
);

  localparam int unsigned IDX_W = (NODE_ENTRIES > 1) ? $clog2(NODE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(NODE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NODE_ENTRIES);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  // Sequencer: each step below uses the shared adder at most once.
  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_SCAN  = 10'b00_0000_0010,  // compare one table entry per cycle
    S_ALLOC = 10'b00_0000_0100,  // new entry: last = now - offset
    S_CHECK = 10'b00_0000_1000,  // blacklisted? bump drop counter
    S_GAP   = 10'b00_0001_0000,  // gap = now - last
    S_RANGE = 10'b00_0010_0000,  // gap <= max_valid_gap ?
    S_MUL   = 10'b00_0100_0000,  // acc = (avg << a) - avg
    S_ADD   = 10'b00_1000_0000,  // avg = (acc + gap) >> a
    S_THR   = 10'b01_0000_0000,  // avg < threshold -> score
    S_DONE  = 10'b10_0000_0000   // present result, write entry back
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic [31:0] max_gap_q, thr_q, offset_q;
  logic [3:0]  max_score_q, alpha_q;

  // persistent counters
  logic [CNT_W-1:0] used_q, used_d;
  logic [31:0]      drop_q, drop_d;

  // transaction working registers
  logic [63:0]      addr_q, addr_d;
  logic [31:0]      now_q, now_d;
  logic [CNT_W-1:0] chk_q, chk_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  entry_t           ent_q, ent_d;
  logic [31:0]      gap_q, gap_d;
  logic [ALU_W-1:0] acc_q, acc_d;
  verdict_e         verdict_q, verdict_d;

  // table and ALU hookup
  logic [IDX_W-1:0] rd_idx;
  entry_t           rd_entry;
  logic             wr_en;
  logic [CNT_W-1:0] chk_nxt;
  alu_op_e          alu_op;
  logic [ALU_W-1:0] alu_a, alu_b, avg_shl, acc_shr;
  alu_res_t         alu_res;
  logic [3:0]       score_inc;

  assign chk_nxt = chk_q + CNT_ONE;

  // lookahead read: in SCAN the next entry is fetched while this one compares
  always_comb begin
    rd_idx = '0;
    if (state_q == S_SCAN) begin
      rd_idx = chk_nxt[IDX_W-1:0];
    end
  end

  // entry changed only on a delivered, tracked transaction
  assign wr_en = (state_q == S_DONE) &&
                 ((verdict_q == V_DELIVER) || (verdict_q == V_NEWBL));

  bcd_table #(
    .NODE_ENTRIES (NODE_ENTRIES)
  ) u_table (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_idx_i   (idx_q),
    .wr_entry_i (ent_q),
    .rd_idx_i   (rd_idx),
    .rd_entry_o (rd_entry)
  );

  // operand selection for the shared adder
  assign avg_shl = {{EXT_W{1'b0}}, ent_q.avg} << alpha_q;

  always_comb begin
    alu_op = ALU_SUB;
    alu_a  = '0;
    alu_b  = '0;
    unique case (state_q)
      S_ALLOC: begin
        alu_a = {{EXT_W{1'b0}}, now_q};
        alu_b = {{EXT_W{1'b0}}, offset_q};
      end
      S_CHECK: begin
        alu_op = ALU_ADD;
        alu_a  = {{EXT_W{1'b0}}, drop_q};
        alu_b  = {{(ALU_W-1){1'b0}}, 1'b1};
      end
      S_GAP: begin
        alu_a = {{EXT_W{1'b0}}, now_q};
        alu_b = {{EXT_W{1'b0}}, ent_q.last};
      end
      S_RANGE: begin
        alu_a = {{EXT_W{1'b0}}, max_gap_q};
        alu_b = {{EXT_W{1'b0}}, gap_q};
      end
      S_MUL: begin
        alu_a = avg_shl;
        alu_b = {{EXT_W{1'b0}}, ent_q.avg};
      end
      S_ADD: begin
        alu_op = ALU_ADD;
        alu_a  = acc_q;
        alu_b  = {{EXT_W{1'b0}}, gap_q};
      end
      S_THR: begin
        alu_a = {{EXT_W{1'b0}}, ent_q.avg};
        alu_b = {{EXT_W{1'b0}}, thr_q};
      end
      S_IDLE, S_SCAN, S_DONE: begin
        alu_op = ALU_SUB;
      end
      default: begin
        alu_op = ALU_SUB;
      end
    endcase
  end

  bcd_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  assign acc_shr   = alu_res.value >> alpha_q;
  assign score_inc = (ent_q.score == SCORE_SAT) ? SCORE_SAT : ent_q.score + 4'd1;

  // sequencer
  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    drop_d    = drop_q;
    addr_d    = addr_q;
    now_d     = now_q;
    chk_d     = chk_q;
    idx_d     = idx_q;
    ent_d     = ent_q;
    gap_d     = gap_q;
    acc_d     = acc_q;
    verdict_d = verdict_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          addr_d    = sender_address_i;
          now_d     = arrival_time_i;
          chk_d     = '0;
          verdict_d = V_DELIVER;
          if (sender_address_i == 64'd0) begin
            verdict_d = V_UNTRACKED;
            state_d   = S_DONE;
          end else if (used_q == '0) begin
            state_d = S_ALLOC;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rd_entry.addr == addr_q) begin
          ent_d   = rd_entry;
          idx_d   = chk_q[IDX_W-1:0];
          state_d = S_CHECK;
        end else if (chk_nxt == used_q) begin
          if (used_q == CNT_FULL) begin
            verdict_d = V_UNTRACKED;
            state_d   = S_DONE;
          end else begin
            state_d = S_ALLOC;
          end
        end else begin
          chk_d = chk_nxt;
        end
      end
      S_ALLOC: begin
        idx_d      = used_q[IDX_W-1:0];
        used_d     = used_q + CNT_ONE;
        ent_d.addr = addr_q;
        ent_d.avg  = '0;
        ent_d.score = '0;
        ent_d.last = alu_res.value[31:0];
        ent_d.bl   = 1'b0;
        state_d    = S_GAP;
      end
      S_CHECK: begin
        if (ent_q.bl) begin
          if (drop_q != DROP_SAT) begin
            drop_d = alu_res.value[31:0];
          end
          verdict_d = V_DROP;
          state_d   = S_DONE;
        end else begin
          state_d = S_GAP;
        end
      end
      S_GAP: begin
        gap_d      = alu_res.value[31:0];
        ent_d.last = now_q;
        state_d    = S_RANGE;
      end
      S_RANGE: begin
        if (alu_res.borrow) begin
          state_d = S_DONE;  // gap too large: only last arrival moves
        end else if (ent_q.avg == '0) begin
          ent_d.avg = gap_q;  // seed
          state_d   = S_THR;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        acc_d   = alu_res.value;
        state_d = S_ADD;
      end
      S_ADD: begin
        ent_d.avg = acc_shr[31:0];
        state_d   = S_THR;
      end
      S_THR: begin
        if (alu_res.borrow) begin
          ent_d.score = score_inc;
          if (score_inc >= max_score_q) begin
            ent_d.bl  = 1'b1;
            verdict_d = V_NEWBL;
          end
        end else if (ent_q.score != '0) begin
          ent_d.score = ent_q.score - 4'd1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
      drop_q  <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      drop_q  <= drop_d;
    end
  end

  // working registers carry no reset
  always_ff @(posedge clk_i) begin
    addr_q    <= addr_d;
    now_q     <= now_d;
    chk_q     <= chk_d;
    idx_q     <= idx_d;
    ent_q     <= ent_d;
    gap_q     <= gap_d;
    acc_q     <= acc_d;
    verdict_q <= verdict_d;
  end

  // config writes; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_gap_q   <= RST_MAX_VALID_GAP;
      thr_q       <= RST_CHEAT_THRESHOLD;
      max_score_q <= RST_MAX_SCORE;
      alpha_q     <= RST_ALPHA_SHIFT;
      offset_q    <= RST_NEW_NODE_OFFSET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_VALID_GAP:   max_gap_q   <= cfg_wdata_i;
        CFG_CHEAT_THRESHOLD: thr_q       <= cfg_wdata_i;
        CFG_MAX_SCORE:       max_score_q <= cfg_wdata_i[3:0];
        CFG_ALPHA_SHIFT:     alpha_q     <= cfg_wdata_i[3:0];
        CFG_NEW_NODE_OFFSET: offset_q    <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // result ports: untracked transactions report a blank entry
  assign busy            = (state_q != S_IDLE);
  assign done_o          = (state_q == S_DONE);
  assign verdict_o       = verdict_q;
  assign entry_index_o   = (verdict_q == V_UNTRACKED) ? 4'd0 : 4'(idx_q);
  assign average_gap_o   = (verdict_q == V_UNTRACKED) ? 32'd0 : ent_q.avg;
  assign score_o         = (verdict_q == V_UNTRACKED) ? 4'd0 : ent_q.score;
  assign dropped_total_o = drop_q;

endmodule

[rtl/bcd_checker.sv]
// ----------------------------------------------------------------------------
// bcd_checker
// Port-level assertions for the backoff cheat detector, bound to the top.
// ----------------------------------------------------------------------------
module bcd_checker import bcd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [1:0]  verdict_o,
  input logic [3:0]  entry_index_o,
  input logic [31:0] average_gap_o,
  input logic [3:0]  score_o,
  input logic [31:0] dropped_total_o
);

  // an accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("not busy after accepted transaction");

  // a result only comes out of a transaction in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe while idle");

  // one strobe per transaction, then idle
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy)
    else $error("result strobe longer than one cycle");

  // untracked result carries a blank entry
  a_untracked_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (verdict_o == V_UNTRACKED) |->
      (entry_index_o == 4'd0) && (average_gap_o == 32'd0) && (score_o == 4'd0))
    else $error("untracked result with entry fields set");

  // drop counter only moves on a drop result
  a_drop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (verdict_o != V_DROP) |-> $stable(dropped_total_o))
    else $error("drop counter moved without a drop");

endmodule

bind backoff_cheat_detector bcd_checker u_bcd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .verdict_o       (verdict_o),
  .entry_index_o   (entry_index_o),
  .average_gap_o   (average_gap_o),
  .score_o         (score_o),
  .dropped_total_o (dropped_total_o)
);
